>>> src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SRL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/srl_pkg.sv
package srl_pkg;

    localparam int OUT_WIDTH = 11;

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LO,
        ST_HI,
        ST_PUT
    } t_state;

    // Status of the search engine as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_srch_stat;

endpackage

>>> src/srl_time_mem.sv
module srl_time_mem #(
    parameter int DEPTH      = 1024,
    parameter int TIME_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  logic [TIME_WIDTH-1:0]      i_wr_data,
    input  logic                       i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic [TIME_WIDTH-1:0]      o_rd_data
);

    logic [TIME_WIDTH-1:0] r_mem [DEPTH];
    logic [TIME_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/srl_search.sv
`include "assert_macros.svh"

module srl_search #(
    parameter int DEPTH      = 1024,
    parameter int TIME_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [TIME_WIDTH-1:0]         i_key,
    input  logic [$clog2(DEPTH+1)-1:0]    i_lo,
    input  logic [$clog2(DEPTH+1)-1:0]    i_hi,
    output logic                          o_rd_en,
    output logic [$clog2(DEPTH)-1:0]      o_rd_addr,
    input  logic [TIME_WIDTH-1:0]         i_rd_data,
    output srl_pkg::t_srch_stat           o_stat,
    output logic [$clog2(DEPTH+1)-1:0]    o_pos
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic                  r_busy, n_busy;
    logic                  r_pend, n_pend;
    logic                  r_done, n_done;
    logic [CW-1:0]         r_lo, n_lo;
    logic [CW-1:0]         r_hi, n_hi;
    logic [CW-1:0]         r_mid, n_mid;
    logic [TIME_WIDTH-1:0] r_key, n_key;
    logic [CW-1:0]         lo_c, hi_c, mid_c;

    // One step per cycle: fold in the entry read last cycle, then issue the next probe.
    always_comb begin
        lo_c = r_lo;
        hi_c = r_hi;
        if (r_pend) begin
            if (i_rd_data <= r_key) begin
                lo_c = r_mid + CW'(1);
            end else begin
                hi_c = r_mid;
            end
        end
        mid_c = lo_c + ((hi_c - lo_c) >> 1);

        n_busy  = r_busy;
        n_pend  = r_pend;
        n_done  = 1'b0;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_key   = r_key;
        o_rd_en = 1'b0;

        if (i_start) begin
            n_lo   = i_lo;
            n_hi   = i_hi;
            n_key  = i_key;
            n_busy = 1'b1;
            n_pend = 1'b0;
        end else if (r_busy) begin
            n_lo = lo_c;
            n_hi = hi_c;
            if (lo_c < hi_c) begin
                o_rd_en = 1'b1;
                n_mid   = mid_c;
                n_pend  = 1'b1;
            end else begin
                n_busy = 1'b0;
                n_pend = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_rd_addr   = mid_c[AW-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_pos       = r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pend <= n_pend;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_key <= n_key;
    end

    `SRL_ASSERT_IMPL(a_window_ordered, i_clk, i_rst_n, r_busy, r_lo <= r_hi)
    `SRL_ASSERT_IMPL(a_read_only_busy, i_clk, i_rst_n, o_rd_en, r_busy && !i_start)
    `SRL_ASSERT_NEXT(a_pend_after_read, i_clk, i_rst_n, o_rd_en, r_pend && r_busy)

endmodule

>>> src/sorted_range_index_locator_top.sv
// Sorted range index locator. The block holds a nondecreasing list of up to DEPTH
// event times in a single-port-read RAM and answers window queries over it. An
// append item (req_type 0) stores time_value at the end of the list in the cycle
// it is accepted; with first_entry set the list restarts with this time as its
// only entry. Appends that would overflow the list or that fall below the last
// stored time are dropped. A query item (req_type 1) names the window
// (range_start, range_end] and produces exactly one result item: hit_count, the
// number of stored times inside the window, and start_index, the 1-based position
// of the first of them, or zero for both when nothing lies in the window. Appends
// produce no result and leave the input ready for the next item. A query whose
// window is empty or inverted, or that arrives while the list is empty, runs no
// search and goes straight to the put state, which loads its result into the
// output register. Any other query runs two binary searches, one after the other,
// on a shared search engine that probes one RAM entry per cycle; each search
// makes at most ceil(log2(N+1)) probes for N stored entries, and the put state
// then loads the result register. The input is not ready while a query is in
// flight, but a finished result waits in the output register and the next item
// is taken in the meantime. A new result that finds the previous one still
// waiting there holds the input off until the consumer takes the older result.
`include "assert_macros.svh"

module sorted_range_index_locator_top #(
    parameter int DEPTH      = 1024,
    parameter int TIME_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_req_type,
    input  logic                         i_first_entry,
    input  logic [31:0]                  i_time_value,
    input  logic [31:0]                  i_range_start,
    input  logic [31:0]                  i_range_end,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [srl_pkg::OUT_WIDTH-1:0] o_start_index,
    output logic [srl_pkg::OUT_WIDTH-1:0] o_hit_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int OW = srl_pkg::OUT_WIDTH;

    srl_pkg::t_state     r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [TIME_WIDTH-1:0] r_last, n_last;
    logic [TIME_WIDTH-1:0] r_key_hi, n_key_hi;
    logic [CW-1:0]       r_below, n_below;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic [OW-1:0]       r_start_index, n_start_index;
    logic [OW-1:0]       r_hit_count, n_hit_count;

    logic                  in_acc;
    logic [TIME_WIDTH+31:0] time_ext, start_ext, end_ext;
    logic [TIME_WIDTH-1:0] t_val, lo_b, hi_b;
    logic [CW+OW-1:0]      idx_ext, cnt_ext;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [TIME_WIDTH-1:0] rd_data;

    logic                  srch_start;
    logic [TIME_WIDTH-1:0] srch_key;
    logic [CW-1:0]         srch_lo, srch_hi;
    srl_pkg::t_srch_stat   srch_stat;
    logic [CW-1:0]         srch_pos;

    // Times and bounds are taken in their low TIME_WIDTH bits.
    assign time_ext  = {{TIME_WIDTH{1'b0}}, i_time_value};
    assign start_ext = {{TIME_WIDTH{1'b0}}, i_range_start};
    assign end_ext   = {{TIME_WIDTH{1'b0}}, i_range_end};
    assign t_val     = time_ext[TIME_WIDTH-1:0];
    assign lo_b      = start_ext[TIME_WIDTH-1:0];
    assign hi_b      = end_ext[TIME_WIDTH-1:0];

    assign idx_ext = {{OW{1'b0}}, r_idx};
    assign cnt_ext = {{OW{1'b0}}, r_cnt};

    assign o_in_ready = (r_state == srl_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_last        = r_last;
        n_key_hi      = r_key_hi;
        n_below       = r_below;
        n_idx         = r_idx;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid;
        n_start_index = r_start_index;
        n_hit_count   = r_hit_count;
        wr_en         = 1'b0;
        wr_addr       = r_count[AW-1:0];
        srch_start    = 1'b0;
        srch_key      = lo_b;
        srch_lo       = '0;
        srch_hi       = r_count;

        // The consumer frees the output register independently of the sequencer.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            srl_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_req_type == srl_pkg::REQ_APPEND) begin
                        if (i_first_entry) begin
                            wr_en   = 1'b1;
                            wr_addr = '0;
                            n_count = CW'(1);
                            n_last  = t_val;
                        end else if ((r_count < CW'(DEPTH)) &&
                                     ((r_count == '0) || (t_val >= r_last))) begin
                            wr_en   = 1'b1;
                            n_count = r_count + CW'(1);
                            n_last  = t_val;
                        end
                    end else if ((lo_b < hi_b) && (r_count != '0)) begin
                        // First search counts the entries not above the lower bound.
                        srch_start = 1'b1;
                        n_key_hi   = hi_b;
                        n_state    = srl_pkg::ST_LO;
                    end else begin
                        n_idx   = '0;
                        n_cnt   = '0;
                        n_state = srl_pkg::ST_PUT;
                    end
                end
            end
            srl_pkg::ST_LO: begin
                if (srch_stat.done) begin
                    // The upper bound's count cannot be below the lower one, so the
                    // second search starts from where the first one ended.
                    n_below    = srch_pos;
                    srch_start = 1'b1;
                    srch_key   = r_key_hi;
                    srch_lo    = srch_pos;
                    n_state    = srl_pkg::ST_HI;
                end
            end
            srl_pkg::ST_HI: begin
                if (srch_stat.done) begin
                    if (srch_pos > r_below) begin
                        n_cnt = srch_pos - r_below;
                        n_idx = r_below + CW'(1);
                    end else begin
                        n_cnt = '0;
                        n_idx = '0;
                    end
                    n_state = srl_pkg::ST_PUT;
                end
            end
            srl_pkg::ST_PUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_start_index = idx_ext[OW-1:0];
                    n_hit_count   = cnt_ext[OW-1:0];
                    n_state       = srl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srl_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last        <= n_last;
        r_key_hi      <= n_key_hi;
        r_below       <= n_below;
        r_idx         <= n_idx;
        r_cnt         <= n_cnt;
        r_start_index <= n_start_index;
        r_hit_count   <= n_hit_count;
    end

    assign o_out_valid   = r_out_valid;
    assign o_start_index = r_start_index;
    assign o_hit_count   = r_hit_count;

    srl_time_mem #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (t_val),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    srl_search #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (srch_start),
        .i_key     (srch_key),
        .i_lo      (srch_lo),
        .i_hi      (srch_hi),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_stat    (srch_stat),
        .o_pos     (srch_pos)
    );

    `SRL_ASSERT_IMPL(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `SRL_ASSERT_IMPL(a_zero_hits_zero_index, i_clk, i_rst_n,
                     r_out_valid && (r_hit_count == '0), r_start_index == '0)
    `SRL_ASSERT_NEXT(a_restart_count, i_clk, i_rst_n,
                     in_acc && (i_req_type == srl_pkg::REQ_APPEND) && i_first_entry,
                     r_count == CW'(1))
    `SRL_ASSERT_IMPL(a_no_write_in_query, i_clk, i_rst_n, wr_en, !srch_stat.busy)

endmodule

>>> sim/sorted_range_index_locator_top_test.sv
// Self-checking test for the sorted range index locator. A scoreboard model of the
// time list follows every accepted item. Each query pushes the expected window answer
// into a queue. A monitor pops the queue on each accepted result and compares fields.
module sorted_range_index_locator_top_test;

    localparam int          ANS_WIDTH    = srl_pkg::OUT_WIDTH;
    localparam int          LIST_DEPTH   = 1024;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [31:0] TIME_MAX     = 32'hFFFF_FFFF;

    typedef struct {
        logic [ANS_WIDTH-1:0] start_index;
        logic [ANS_WIDTH-1:0] hit_count;
    } t_window_answer;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        i_req_type    = srl_pkg::REQ_APPEND;
    logic        i_first_entry = 1'b0;
    logic [31:0] i_time_value  = '0;
    logic [31:0] i_range_start = '0;
    logic [31:0] i_range_end   = '0;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [ANS_WIDTH-1:0] o_start_index;
    logic [ANS_WIDTH-1:0] o_hit_count;

    sorted_range_index_locator_top #(
        .DEPTH      (LIST_DEPTH),
        .TIME_WIDTH (32)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_first_entry (i_first_entry),
        .i_time_value  (i_time_value),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_start_index (o_start_index),
        .o_hit_count   (o_hit_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Scoreboard copy of the time list and the answers still owed by the block.
    logic [31:0]    list_times [LIST_DEPTH];
    int unsigned    list_len = 0;
    t_window_answer expected_answers [$];

    // Idle rates in percent for the sender and the receiver.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    int unsigned appends_kept    = 0;
    int unsigned appends_dropped = 0;
    int unsigned queries_sent    = 0;
    int unsigned answers_checked = 0;
    int unsigned fail_count      = 0;

    // Number of stored times at or below v. A plain scan keeps the model simple.
    function automatic int unsigned times_at_or_below(logic [31:0] v);
        int unsigned n = 0;
        for (int unsigned k = 0; k < list_len; k++) begin
            if (list_times[k] <= v) n++;
        end
        return n;
    endfunction

    // Applies one accepted item to the model. A query queues its window answer.
    function automatic void track_item(logic req, logic first, logic [31:0] t,
                                       logic [31:0] rs, logic [31:0] re);
        t_window_answer ans;
        int unsigned    below;
        int unsigned    upto;
        if (req == srl_pkg::REQ_APPEND) begin
            if (first) begin
                list_times[0] = t;
                list_len      = 1;
                appends_kept++;
            end else if (list_len < LIST_DEPTH &&
                         (list_len == 0 || t >= list_times[list_len-1])) begin
                list_times[list_len] = t;
                list_len++;
                appends_kept++;
            end else begin
                appends_dropped++;
            end
        end else begin
            ans.start_index = '0;
            ans.hit_count   = '0;
            if (rs < re && list_len > 0) begin
                below = times_at_or_below(rs);
                upto  = times_at_or_below(re);
                if (upto > below) begin
                    ans.hit_count   = ANS_WIDTH'(upto - below);
                    ans.start_index = ANS_WIDTH'(below + 1);
                end
            end
            expected_answers.push_back(ans);
            queries_sent++;
        end
    endfunction

    // Drives one item and holds it until the block takes it. Random idle cycles
    // go in front of the item according to the current sender idle rate.
    task automatic send_item(input logic req, input logic first, input logic [31:0] t,
                             input logic [31:0] rs, input logic [31:0] re);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_first_entry <= first;
        i_time_value  <= t;
        i_range_start <= rs;
        i_range_end   <= re;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        track_item(req, first, t, rs, re);
    endtask

    // The fields that an item type ignores always carry random junk.
    task automatic append_time(input logic first, input logic [31:0] t);
        send_item(srl_pkg::REQ_APPEND, first, t, $urandom, $urandom);
    endtask

    task automatic query_window(input logic [31:0] rs, input logic [31:0] re);
        send_item(srl_pkg::REQ_QUERY, 1'($urandom_range(1)), $urandom, rs, re);
    endtask

    // A window bound: mostly a stored time or one of its neighbors, so that the
    // window edges land right on list entries, else a random value or an extreme.
    function automatic logic [31:0] pick_bound();
        int unsigned sel = $urandom_range(99);
        logic [31:0] b;
        if (sel < 60 && list_len > 0) begin
            b = list_times[$urandom_range(list_len - 1, 0)];
            case ($urandom_range(2))
                0:       b = b - 1;
                1:       b = b + 1;
                default: ;
            endcase
        end else if (sel < 88) begin
            b = $urandom;
            if ($urandom_range(1)) b = b >> $urandom_range(31, 1);
        end else begin
            b = $urandom_range(1) ? TIME_MAX : 32'h0;
        end
        return b;
    endfunction

    task automatic probe_random_window();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] tmp;
        a = pick_bound();
        b = pick_bound();
        // Most windows are well formed; the rest stay inverted or get collapsed.
        if ($urandom_range(99) < 80 && a > b) begin
            tmp = a;
            a   = b;
            b   = tmp;
        end
        if ($urandom_range(99) < 5) b = a;
        query_window(a, b);
    endtask

    // Next time for an ordered append, saturating at the top of the time range.
    function automatic logic [31:0] next_time(logic [31:0] step_cap);
        logic [32:0] sum;
        if (list_len == 0) return $urandom;
        sum = {1'b0, list_times[list_len-1]} + {1'b0, 32'($urandom_range(step_cap, 0))};
        return sum[32] ? TIME_MAX : sum[31:0];
    endfunction

    // Extremes of every field, each item type, and the named corner cases:
    // empty list, duplicates, out-of-order appends, inverted and empty windows,
    // windows that miss every entry, and restarting the list.
    task automatic test_corner_cases();
        send_idle_pct  = 7;
        recv_stall_pct = 80;
        query_window(32'h0, TIME_MAX);          // nothing stored yet
        append_time(1'b1, 32'd100);
        append_time(1'b0, 32'd100);             // duplicate time is kept
        append_time(1'b0, 32'd50);              // below the last time, dropped
        append_time(1'b0, 32'd200);
        append_time(1'b0, TIME_MAX);
        query_window(32'h0, TIME_MAX);
        query_window(32'd100, 32'd200);
        query_window(32'd200, 32'd100);         // inverted window
        query_window(32'd150, 32'd150);         // empty window
        query_window(32'd99, 32'd100);
        query_window(32'd200, 32'hFFFF_FFFE);   // window between two entries
        query_window(32'hFFFF_FFFE, TIME_MAX);
        query_window(TIME_MAX, TIME_MAX);
        append_time(1'b1, 32'h0);               // restart with the smallest time
        query_window(32'h0, TIME_MAX);
        append_time(1'b1, TIME_MAX);
        append_time(1'b0, 32'd5);
        query_window(32'h0, TIME_MAX);
        query_window(32'h7FFF_FFFF, 32'h8000_0000);
    endtask

    // Fills the list to capacity, checks that further appends are dropped, and
    // queries the largest possible index and count before restarting the list.
    task automatic test_full_list();
        logic [31:0] t;
        send_idle_pct  = 7;
        recv_stall_pct = 80;
        t = $urandom_range(1000, 1);
        append_time(1'b1, t);
        for (int k = 1; k < LIST_DEPTH; k++) begin
            // The final step is nonzero so the last entry stands alone.
            t = t + ((k == LIST_DEPTH - 1) ? $urandom_range(3, 1) : $urandom_range(3, 0));
            append_time(1'b0, t);
        end
        append_time(1'b0, t + 1);
        append_time(1'b0, TIME_MAX);
        append_time(1'b0, t);
        query_window(32'h0, TIME_MAX);
        query_window(list_times[LIST_DEPTH-2], TIME_MAX);
        query_window(list_times[0] - 1, list_times[0]);
        query_window(list_times[LIST_DEPTH/2-1], list_times[LIST_DEPTH/2]);
        repeat (12) probe_random_window();
        append_time(1'b1, $urandom);
        query_window(32'h0, TIME_MAX);
        query_window(list_times[0] - 1, list_times[0]);
    endtask

    // Lists of random length built from ordered appends with random steps, with
    // queries mixed in, plus some out-of-order and random appends as noise.
    task automatic test_random_traffic(input int unsigned send_idle,
                                       input int unsigned recv_stall,
                                       input int unsigned n_items);
        int unsigned goal;
        int unsigned seq_len;
        int unsigned noise;
        logic [31:0] step_cap;
        logic [31:0] base;
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        goal = appends_kept + queries_sent + n_items;
        while (appends_kept + queries_sent < goal) begin
            seq_len = ($urandom_range(9) == 0) ? $urandom_range(200, 30)
                                               : $urandom_range(24, 1);
            case ($urandom_range(3))
                0:       step_cap = 32'd1;
                1:       step_cap = 32'd20;
                2:       step_cap = 32'd100000;
                default: step_cap = $urandom >> $urandom_range(31, 4);
            endcase
            base = $urandom;
            if ($urandom_range(1)) base = base >> $urandom_range(31, 1);
            append_time(1'b1, base);
            for (int k = 1; k < seq_len; k++) begin
                noise = $urandom_range(99);
                if (noise < 6 && list_times[list_len-1] != 32'h0) begin
                    append_time(1'b0, $urandom_range(list_times[list_len-1] - 1, 0));
                end else if (noise < 9) begin
                    append_time(1'b0, $urandom);
                end else begin
                    append_time(1'b0, next_time(step_cap));
                end
                if ($urandom_range(99) < 25) probe_random_window();
            end
            repeat ($urandom_range(8, 2)) probe_random_window();
        end
    endtask

    // The receiver stalls at random at the current stall rate.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Each accepted result must match the oldest owed answer, field by field.
    always @(posedge i_clk) begin : check_results
        t_window_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_answers.size() == 0) begin
                $error("result with no pending query: start_index %0d hit_count %0d",
                       o_start_index, o_hit_count);
                fail_count++;
            end else begin
                want = expected_answers.pop_front();
                answers_checked++;
                if (o_start_index !== want.start_index) begin
                    $error("start_index mismatch: expected %0d, got %0d",
                           want.start_index, o_start_index);
                    fail_count++;
                end
                if (o_hit_count !== want.hit_count) begin
                    $error("hit_count mismatch: expected %0d, got %0d",
                           want.hit_count, o_hit_count);
                    fail_count++;
                end
            end
        end
    end

    initial begin : run_tests
        int unsigned waited;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_cases();
        test_full_list();
        test_random_traffic(7, 80, 64);
        test_random_traffic(80, 7, 64);
        test_random_traffic(0, 0, 64);

        // Stop sending, collect the answers still owed, then let the block settle
        // so that any stray result would still show up.
        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_answers.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_answers.size() != 0) begin
            $error("%0d query results never arrived", expected_answers.size());
            fail_count++;
        end

        $display("Covered %0d queries (%0d results checked), %0d stored appends, %0d dropped.",
                 queries_sent, answers_checked, appends_kept, appends_dropped);
        $display("Included a full list, window corner cases and three idle/stall mixes.");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: far above the slowest legal run.
    initial begin
        #4000000;
        $error("run timed out");
        $display("TB_ERROR");
        $finish;
    end

endmodule
